@@ src/rtlc_pkg.sv @@
package rtlc_pkg;

  localparam int unsigned AddrW = 39;
  localparam int unsigned FlagW = 4;
  localparam int unsigned MaxRegionsDef = 16;
  localparam int unsigned PageBytesDef = 4096;

  localparam logic [1:0] OpInsert = 2'd0;
  localparam logic [1:0] OpLookup = 2'd1;
  localparam logic [1:0] OpCheck  = 2'd2;
  localparam logic [1:0] OpClear  = 2'd3;

  localparam logic [1:0] StOk      = 2'd0;
  localparam logic [1:0] StEmpty   = 2'd1;
  localparam logic [1:0] StOverlap = 2'd2;
  localparam logic [1:0] StFull    = 2'd3;

  localparam logic CfgUserStart = 1'b0;
  localparam logic CfgUserTop   = 1'b1;

  typedef struct packed {
    logic [1:0]       operation;
    logic [AddrW-1:0] address;
    logic [AddrW-1:0] region_limit;
    logic [AddrW-1:0] length;
    logic [FlagW-1:0] permission_flags;
    logic             write_access;
  } req_t;

  typedef struct packed {
    logic [1:0]       status;
    logic             hit;
    logic [AddrW-1:0] found_start;
    logic [AddrW-1:0] found_end;
    logic [FlagW-1:0] found_flags;
    logic             access_ok;
  } rsp_t;

  typedef enum logic [2:0] {
    CmdNone, CmdLoad, CmdScan, CmdShift, CmdWriteNew, CmdClear, CmdDone
  } cmd_e;

  typedef struct packed {
    cmd_e cmd;
  } ctrl_t;

  // datapath status back to the controller
  typedef struct packed {
    logic scan_end;   // scan reached count or a decision
    logic need_shift; // insert lands this cycle, shift next
    logic shift_end;
    logic walk_more;  // check walk must continue
  } stat_t;

endpackage

@@ src/rtlc_ctrl.sv @@
module rtlc_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  output logic            busy_o,
  input  rtlc_pkg::stat_t stat_i,
  output rtlc_pkg::ctrl_t ctrl_o
);

  localparam logic [2:0] SIdle = 3'd0;
  localparam logic [2:0] SScan = 3'd1;
  localparam logic [2:0] SShift = 3'd2;
  localparam logic [2:0] SDone = 3'd3;

  logic [2:0] state_q, state_d;

  // sequence load, scan, shift, result
  always_comb begin
    state_d = state_q;
    ctrl_o.cmd = rtlc_pkg::CmdNone;
    unique case (state_q)
      SIdle: begin
        if (start_i) begin
          ctrl_o.cmd = rtlc_pkg::CmdLoad;
          state_d = SScan;
        end
      end
      SScan: begin
        ctrl_o.cmd = rtlc_pkg::CmdScan;
        if (stat_i.scan_end && !stat_i.walk_more) begin
          state_d = stat_i.need_shift ? SShift : SDone;
        end
      end
      SShift: begin
        ctrl_o.cmd = stat_i.shift_end ? rtlc_pkg::CmdWriteNew : rtlc_pkg::CmdShift;
        if (stat_i.shift_end) state_d = SDone;
      end
      SDone: begin
        ctrl_o.cmd = rtlc_pkg::CmdDone;
        state_d = SIdle;
      end
      default: state_d = SIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= SIdle;
    else state_q <= state_d;
  end

  assign busy_o = (state_q != SIdle);

  a_done_from_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == SDone |-> $past(state_q) == SScan || $past(state_q) == SShift)
    else $error("done without work");
  a_idle_after_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == SDone |=> state_q == SIdle) else $error("done not one cycle");
  a_start_leaves_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == SIdle && start_i |=> state_q == SScan) else $error("start lost");

endmodule

@@ src/rtlc_dp.sv @@
module rtlc_dp #(
  parameter int unsigned MaxRegions = rtlc_pkg::MaxRegionsDef,
  parameter int unsigned PageBytes  = rtlc_pkg::PageBytesDef
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  rtlc_pkg::req_t  req_i,
  input  logic            cfg_we_i,
  input  logic            cfg_idx_i,
  input  logic [rtlc_pkg::AddrW-1:0] cfg_data_i,
  input  rtlc_pkg::ctrl_t ctrl_i,
  output rtlc_pkg::stat_t stat_o,
  output logic            done_o,
  output rtlc_pkg::rsp_t  rsp_o
);

  localparam int unsigned AW = rtlc_pkg::AddrW;
  localparam int unsigned FW = rtlc_pkg::FlagW;
  localparam int unsigned IW = $clog2(MaxRegions);
  localparam int unsigned CW = $clog2(MaxRegions + 1);
  localparam int unsigned EW = AW + FW + AW;

  // region entries, {start, end, flags}, kept in registers: shifted per entry
  logic [EW-1:0] ent_q [MaxRegions];
  logic [CW-1:0] cnt_q;
  logic [IW-1:0] last_q;
  logic          last_v_q;
  logic [AW-1:0] ustart_q, utop_q;

  rtlc_pkg::req_t req_q;
  logic [CW-1:0]  idx_q;   // scan pointer
  logic [AW:0]    cur_q;   // check walk address
  logic [AW:0]    end_q;
  logic           tried_last_q;
  logic           found_q, ok_q;
  logic [1:0]     stat_q;
  logic [CW-1:0]  pos_q;
  logic [EW-1:0]  fnd_q;

  logic [IW-1:0]  rd_idx;
  logic [EW-1:0]  ent;
  logic [AW-1:0]  e_s, e_e;
  logic [FW-1:0]  e_f;
  logic           at_end;
  logic           use_last;
  logic           contains;
  logic [AW-1:0]  qaddr;
  logic           bounds_ok;
  logic [AW:0]    sum;
  logic           stp_end, stp_more, stp_fail;
  logic           prev_ovl, next_ovl, tbl_full, ins_go;
  rtlc_pkg::rsp_t rsp_d;

  // try the last hit first, for lookup and check only
  assign use_last = (req_q.operation != rtlc_pkg::OpInsert) && !tried_last_q && last_v_q
                    && ({1'b0, last_q} < cnt_q);
  assign rd_idx = use_last ? last_q : idx_q[IW-1:0];
  assign ent = ent_q[rd_idx];
  assign e_s = ent[EW-1 -: AW];
  assign e_e = ent[AW+FW-1 -: AW];
  assign e_f = ent[FW-1:0];
  assign at_end = !use_last && (idx_q >= cnt_q);
  assign qaddr = (req_q.operation == rtlc_pkg::OpCheck) ? cur_q[AW-1:0] : req_q.address;
  assign contains = (e_s <= qaddr) && (qaddr < e_e);

  // per-entry step outcome
  always_comb begin
    stp_end = 1'b0;
    stp_more = 1'b0;
    stp_fail = 1'b0;
    unique case (req_q.operation)
      rtlc_pkg::OpInsert: stp_end = at_end || (e_s > req_q.address) || stat_q != rtlc_pkg::StOk;
      rtlc_pkg::OpLookup: stp_end = at_end || contains;
      rtlc_pkg::OpCheck: begin
        if (!ok_q) stp_end = 1'b1;
        else if (at_end) begin
          stp_end = 1'b1;
          stp_fail = 1'b1;
        end else if (contains) begin
          stp_end = 1'b1;
          if (!(req_q.write_access ? e_f[1] : e_f[0])) stp_fail = 1'b1;
          else if (req_q.write_access && e_f[3] &&
                   ({1'b0, qaddr} < {1'b0, e_s} + (AW+1)'(PageBytes))) stp_fail = 1'b1;
          else stp_more = ({1'b0, e_e} < end_q);
        end
      end
      default: stp_end = 1'b1;
    endcase
  end

  // insert decision at the sorted position: check both neighbors, then room
  assign prev_ovl = (idx_q != '0) && (ent_q[IW'(idx_q - 1'b1)][AW+FW-1 -: AW] > req_q.address);
  assign next_ovl = !at_end && (req_q.region_limit > e_s);
  assign tbl_full = (cnt_q >= CW'(MaxRegions));
  assign ins_go = (req_q.operation == rtlc_pkg::OpInsert) && stp_end
                  && (stat_q == rtlc_pkg::StOk) && !prev_ovl && !next_ovl && !tbl_full;

  assign sum = {1'b0, req_i.address} + {1'b0, req_i.length};
  assign bounds_ok = (ustart_q <= req_i.address) && ({1'b0, req_i.address} < sum)
                     && (sum <= {1'b0, utop_q});

  assign stat_o.scan_end   = stp_end;
  assign stat_o.walk_more  = stp_more;
  assign stat_o.need_shift = ins_go;
  assign stat_o.shift_end  = (idx_q == pos_q);

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ustart_q <= AW'(64'h200000);
      utop_q   <= AW'(64'h80000000);
    end else if (cfg_we_i) begin
      if (cfg_idx_i == rtlc_pkg::CfgUserStart) ustart_q <= cfg_data_i;
      else utop_q <= cfg_data_i;
    end
  end

  // control state of the table
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      last_q <= '0;
      last_v_q <= 1'b0;
      done_o <= 1'b0;
    end else begin
      done_o <= (ctrl_i.cmd == rtlc_pkg::CmdDone);
      if (ctrl_i.cmd == rtlc_pkg::CmdLoad && req_i.operation == rtlc_pkg::OpClear) begin
        cnt_q <= '0;
        last_v_q <= 1'b0;
        last_q <= '0;
      end
      if (ctrl_i.cmd == rtlc_pkg::CmdScan && req_q.operation != rtlc_pkg::OpInsert
          && contains && !at_end && !(req_q.operation == rtlc_pkg::OpCheck && !ok_q)) begin
        last_q <= rd_idx;
        last_v_q <= 1'b1;
      end
      if (ctrl_i.cmd == rtlc_pkg::CmdWriteNew) begin
        cnt_q <= cnt_q + 1'b1;
        if (last_v_q && {1'b0, last_q} >= pos_q) last_q <= last_q + 1'b1;
      end
    end
  end

  // scan and item working registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_q <= '0;
      idx_q <= '0;
      tried_last_q <= 1'b0;
      found_q <= 1'b0;
      cur_q <= '0;
      end_q <= '0;
      ok_q <= 1'b0;
      stat_q <= rtlc_pkg::StOk;
      pos_q <= '0;
      fnd_q <= '0;
    end else begin
      unique case (ctrl_i.cmd)
        rtlc_pkg::CmdLoad: begin
          req_q <= req_i;
          idx_q <= '0;
          tried_last_q <= 1'b0;
          found_q <= 1'b0;
          cur_q <= {1'b0, req_i.address};
          end_q <= sum;
          ok_q <= (req_i.operation == rtlc_pkg::OpCheck) ? bounds_ok : 1'b0;
          stat_q <= (req_i.address >= req_i.region_limit) ? rtlc_pkg::StEmpty
                                                          : rtlc_pkg::StOk;
        end
        rtlc_pkg::CmdScan: begin
          // restart the walk at the region end, jump to the top to shift, mark the last hit tried, or advance
          if (req_q.operation == rtlc_pkg::OpCheck && stp_more) begin
            cur_q <= {1'b0, e_e};
            idx_q <= '0;
            tried_last_q <= 1'b0;
          end else if (ins_go) begin
            idx_q <= cnt_q;
          end else if (use_last) begin
            tried_last_q <= 1'b1;
          end else begin
            idx_q <= idx_q + 1'b1;
          end
          if (req_q.operation == rtlc_pkg::OpLookup && contains && !at_end) begin
            found_q <= 1'b1;
            fnd_q <= ent;
          end
          if (req_q.operation == rtlc_pkg::OpCheck && stp_fail) ok_q <= 1'b0;
          if (req_q.operation == rtlc_pkg::OpInsert && stp_end
              && stat_q == rtlc_pkg::StOk) begin
            pos_q <= idx_q;
            if (prev_ovl || next_ovl) stat_q <= rtlc_pkg::StOverlap;
            else if (tbl_full) stat_q <= rtlc_pkg::StFull;
          end
        end
        rtlc_pkg::CmdShift: idx_q <= idx_q - 1'b1;
        default: ;
      endcase
    end
  end

  // table entries: shift up by one, then write the new region
  always_ff @(posedge clk_i) begin
    if (ctrl_i.cmd == rtlc_pkg::CmdShift)
      ent_q[idx_q[IW-1:0]] <= ent_q[IW'(idx_q - 1'b1)];
    else if (ctrl_i.cmd == rtlc_pkg::CmdWriteNew)
      ent_q[pos_q[IW-1:0]] <= {req_q.address, req_q.region_limit, req_q.permission_flags};
  end

  // assemble the result item
  always_comb begin
    rsp_d = '0;
    unique case (req_q.operation)
      rtlc_pkg::OpInsert: rsp_d.status = stat_q;
      rtlc_pkg::OpLookup: if (found_q) begin
        rsp_d.hit = 1'b1;
        rsp_d.found_start = fnd_q[EW-1 -: AW];
        rsp_d.found_end = fnd_q[AW+FW-1 -: AW];
        rsp_d.found_flags = fnd_q[FW-1:0];
      end
      rtlc_pkg::OpCheck: rsp_d.access_ok = ok_q;
      default: ;
    endcase
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) rsp_o <= '0;
    else if (ctrl_i.cmd == rtlc_pkg::CmdDone) rsp_o <= rsp_d;
  end

  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CW'(MaxRegions)) else $error("count overflow");
  a_last_in_table: assert property (@(posedge clk_i) disable iff (!rst_ni)
    last_v_q |-> cnt_q != '0) else $error("last hit on empty table");
  a_grow_on_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_i.cmd == rtlc_pkg::CmdWriteNew |=> cnt_q == $past(cnt_q) + 1'b1)
    else $error("count not advanced");

endmodule

@@ src/region_table_lookup_and_check.sv @@
// Channel | Direction | Handshake          | Payload
// request | in        | start_i / busy_o   | req_i (rtlc_pkg::req_t)
// result  | out       | rsp_valid_o strobe | rsp_o (rtlc_pkg::rsp_t)
// config  | in        | cfg_valid_i/ready  | cfg_index_i, cfg_data_i
// An item is loaded, then scans the table one entry per cycle (a check walk rescans per
// region), then its result is registered and strobed. An insert that lands first shifts
// the entries above its position up, one at a time, and then writes the new region.
// busy_o drops in the strobe cycle, so the next item may be accepted with the result.
// Reset clears the region count and the last hit; entries need no clearing.
// Results cannot be stalled; config is always ready.
module region_table_lookup_and_check #(
  parameter int unsigned MaxRegions = rtlc_pkg::MaxRegionsDef,
  parameter int unsigned PageBytes  = rtlc_pkg::PageBytesDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  output logic                          busy_o,
  input  rtlc_pkg::req_t                req_i,
  output logic                          rsp_valid_o,
  output rtlc_pkg::rsp_t                rsp_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic                          cfg_index_i,
  input  logic [rtlc_pkg::AddrW-1:0]    cfg_data_i
);

  rtlc_pkg::ctrl_t ctrl;
  rtlc_pkg::stat_t stat;

  assign cfg_ready_o = 1'b1;

  rtlc_ctrl u_ctrl (
    .clk_i, .rst_ni, .start_i, .busy_o, .stat_i(stat), .ctrl_o(ctrl)
  );

  rtlc_dp #(.MaxRegions(MaxRegions), .PageBytes(PageBytes)) u_dp (
    .clk_i, .rst_ni, .req_i,
    .cfg_we_i(cfg_valid_i), .cfg_idx_i(cfg_index_i), .cfg_data_i,
    .ctrl_i(ctrl), .stat_o(stat), .done_o(rsp_valid_o), .rsp_o
  );

endmodule

@@ dv/region_table_lookup_and_check_test.sv @@
module region_table_lookup_and_check_test;

  localparam int unsigned AddrW = rtlc_pkg::AddrW;
  localparam int unsigned FlagW = rtlc_pkg::FlagW;
  localparam int unsigned NumRegions = rtlc_pkg::MaxRegionsDef;
  localparam logic [AddrW-1:0] PageSize = AddrW'(rtlc_pkg::PageBytesDef);
  localparam longint unsigned CycleLimit = 2000000;

  logic clk;
  logic rst_n;
  logic start;
  logic busy;
  rtlc_pkg::req_t req;
  logic rsp_valid;
  rtlc_pkg::rsp_t rsp;
  logic cfg_valid;
  logic cfg_ready;
  logic cfg_index;
  logic [AddrW-1:0] cfg_data;

  region_table_lookup_and_check i_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .start_i     (start),
    .busy_o      (busy),
    .req_i       (req),
    .rsp_valid_o (rsp_valid),
    .rsp_o       (rsp),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  // Shadow copy of the region table and user bounds
  logic [AddrW-1:0] tbl_start [NumRegions];
  logic [AddrW-1:0] tbl_end [NumRegions];
  logic [FlagW-1:0] tbl_flags [NumRegions];
  int unsigned      tbl_count;
  int unsigned      last_idx;
  bit               last_valid;
  logic [AddrW-1:0] user_lo;
  logic [AddrW-1:0] user_hi;

  rtlc_pkg::rsp_t  pending_rsp[$];
  int unsigned     n_mismatch;
  int unsigned     n_items;
  int unsigned     n_rsp;
  int unsigned     n_hits;
  int unsigned     n_ok_checks;
  longint unsigned n_cycles;

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  // Bound the run
  always @(posedge clk) begin
    n_cycles <= n_cycles + 1;
    if (n_cycles > CycleLimit) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // Find the region holding an address, updating the last hit
  function automatic int find_region(logic [AddrW-1:0] a);
    if (last_valid && last_idx < tbl_count && tbl_start[last_idx] <= a &&
        a < tbl_end[last_idx])
      return last_idx;
    for (int i = 0; i < tbl_count; i++) begin
      if (tbl_start[i] <= a && a < tbl_end[i]) begin
        last_idx = i;
        last_valid = 1'b1;
        return i;
      end
    end
    return -1;
  endfunction

  function automatic logic [1:0] insert_region(logic [AddrW-1:0] s, logic [AddrW-1:0] e,
                                               logic [FlagW-1:0] fl);
    int unsigned pos;
    pos = 0;
    if (s >= e) return rtlc_pkg::StEmpty;
    while (pos < tbl_count && tbl_start[pos] <= s) pos++;
    if (pos > 0 && tbl_end[pos-1] > s) return rtlc_pkg::StOverlap;
    if (pos < tbl_count && e > tbl_start[pos]) return rtlc_pkg::StOverlap;
    if (tbl_count >= NumRegions) return rtlc_pkg::StFull;
    for (int i = tbl_count; i > pos; i--) begin
      tbl_start[i] = tbl_start[i-1];
      tbl_end[i] = tbl_end[i-1];
      tbl_flags[i] = tbl_flags[i-1];
    end
    tbl_start[pos] = s;
    tbl_end[pos] = e;
    tbl_flags[pos] = fl;
    tbl_count++;
    if (last_valid && last_idx >= pos) last_idx++;
    return rtlc_pkg::StOk;
  endfunction

  function automatic logic check_access(logic [AddrW-1:0] a, logic [AddrW-1:0] len, logic wr);
    logic [AddrW:0] cur;
    logic [AddrW:0] stop;
    int k;
    cur = {1'b0, a};
    stop = {1'b0, a} + {1'b0, len};
    if (!(user_lo <= a && {1'b0, a} < stop && stop <= {1'b0, user_hi})) return 1'b0;
    while (cur < stop) begin
      k = find_region(cur[AddrW-1:0]);
      if (k < 0) return 1'b0;
      if (!(wr ? tbl_flags[k][1] : tbl_flags[k][0])) return 1'b0;
      if (wr && tbl_flags[k][3] &&
          cur < ({1'b0, tbl_start[k]} + {1'b0, PageSize})) return 1'b0;
      cur = {1'b0, tbl_end[k]};
    end
    return 1'b1;
  endfunction

  function automatic rtlc_pkg::rsp_t predict_result(rtlc_pkg::req_t r);
    rtlc_pkg::rsp_t o;
    int k;
    o = '0;
    unique case (r.operation)
      rtlc_pkg::OpInsert: o.status = insert_region(r.address, r.region_limit,
                                                   r.permission_flags);
      rtlc_pkg::OpLookup: begin
        k = find_region(r.address);
        if (k >= 0) begin
          o.hit = 1'b1;
          o.found_start = tbl_start[k];
          o.found_end = tbl_end[k];
          o.found_flags = tbl_flags[k];
        end
      end
      rtlc_pkg::OpCheck: o.access_ok = check_access(r.address, r.length, r.write_access);
      default: begin
        tbl_count = 0;
        last_valid = 1'b0;
        last_idx = 0;
      end
    endcase
    return o;
  endfunction

  // Compare each strobed result with the oldest expectation
  always @(posedge clk) begin
    rtlc_pkg::rsp_t exp_rsp;
    if (rst_n && rsp_valid) begin
      n_rsp++;
      if (pending_rsp.size() == 0) begin
        n_mismatch++;
        if (n_mismatch <= 10) $display("unexpected result %p", rsp);
      end else begin
        exp_rsp = pending_rsp.pop_front();
        if (rsp.status !== exp_rsp.status || rsp.hit !== exp_rsp.hit ||
            rsp.found_start !== exp_rsp.found_start ||
            rsp.found_end !== exp_rsp.found_end ||
            rsp.found_flags !== exp_rsp.found_flags ||
            rsp.access_ok !== exp_rsp.access_ok) begin
          n_mismatch++;
          if (n_mismatch <= 10)
            $display("mismatch: expected %p, got %p", exp_rsp, rsp);
        end else begin
          if (exp_rsp.hit) n_hits++;
          if (exp_rsp.access_ok) n_ok_checks++;
        end
      end
    end
  end

  // Send one item after a random gap, predict at acceptance
  task automatic send_item(rtlc_pkg::req_t r);
    int unsigned gap;
    gap = $urandom_range(0, 8);
    if ($urandom_range(0, 3) == 0) gap = 0;
    repeat (gap) @(posedge clk);
    start <= 1'b1;
    req <= r;
    @(posedge clk);
    while (busy) @(posedge clk);
    pending_rsp.push_back(predict_result(r));
    n_items++;
    // drop start before waiting on the clock again; the block is busy then anyway
    start <= 1'b0;
    @(posedge clk);
  endtask

  task automatic drain_results();
    while (pending_rsp.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Write a bound register while idle
  task automatic write_bound(logic idx, logic [AddrW-1:0] val);
    drain_results();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    if (idx == rtlc_pkg::CfgUserStart) user_lo = val;
    else user_hi = val;
  endtask

  function automatic rtlc_pkg::req_t make_req(logic [1:0] op, logic [AddrW-1:0] a,
                                              logic [AddrW-1:0] lim, logic [AddrW-1:0] len,
                                              logic [FlagW-1:0] fl, logic wr);
    rtlc_pkg::req_t r;
    r.operation = op;
    r.address = a;
    r.region_limit = lim;
    r.length = len;
    r.permission_flags = fl;
    r.write_access = wr;
    return r;
  endfunction

  function automatic logic [AddrW-1:0] rand_addr();
    return AddrW'({$urandom(), $urandom()});
  endfunction

  // Directed: every status, lookups, checks incl. stack guard, clear
  task automatic test_directed();
    send_item(make_req(rtlc_pkg::OpInsert, 39'h300000, 39'h300000, '0, 4'h3, 1'b0));
    send_item(make_req(rtlc_pkg::OpInsert, 39'h400000, 39'h300000, '0, 4'h3, 1'b0));
    send_item(make_req(rtlc_pkg::OpInsert, 39'h300000, 39'h310000, '0, 4'h3, 1'b0));
    send_item(make_req(rtlc_pkg::OpInsert, 39'h310000, 39'h320000, '0, 4'hb, 1'b0));
    send_item(make_req(rtlc_pkg::OpInsert, 39'h300000, 39'h301000, '0, 4'h1, 1'b0));
    send_item(make_req(rtlc_pkg::OpInsert, 39'h2ff000, 39'h300001, '0, 4'h1, 1'b0));
    send_item(make_req(rtlc_pkg::OpInsert, 39'h200000, 39'h300000, '0, 4'h1, 1'b0));
    send_item(make_req(rtlc_pkg::OpLookup, 39'h310fff, '0, '0, '0, 1'b0));
    send_item(make_req(rtlc_pkg::OpLookup, 39'h320000, '0, '0, '0, 1'b0));
    send_item(make_req(rtlc_pkg::OpLookup, '1, '0, '0, '0, 1'b0));
    send_item(make_req(rtlc_pkg::OpCheck, 39'h200000, '0, 39'h120000, '0, 1'b0));
    send_item(make_req(rtlc_pkg::OpCheck, 39'h300000, '0, 39'h20000, '0, 1'b1));
    send_item(make_req(rtlc_pkg::OpCheck, 39'h311000, '0, 39'h1000, '0, 1'b1));
    send_item(make_req(rtlc_pkg::OpCheck, 39'h300000, '0, '0, '0, 1'b0));
    send_item(make_req(rtlc_pkg::OpCheck, '1, '0, '1, '0, 1'b1));
    send_item(make_req(rtlc_pkg::OpCheck, 39'h1000, '0, 39'h1000, '0, 1'b0));
    for (int i = 0; i < 14; i++)
      send_item(make_req(rtlc_pkg::OpInsert, 39'h1000000 + AddrW'(i) * 39'h10000,
                         39'h1008000 + AddrW'(i) * 39'h10000, '0, 4'(i), 1'b0));
    send_item(make_req(rtlc_pkg::OpInsert, 39'h7f_ffff_fffe, 39'h7f_ffff_ffff, '0,
                       4'hf, 1'b1));
    send_item(make_req(rtlc_pkg::OpClear, '1, '1, '1, 4'hf, 1'b1));
    send_item(make_req(rtlc_pkg::OpLookup, 39'h300000, '0, '0, '0, 1'b0));
  endtask

  // Random: mostly well-formed inserts and queries near a moving base
  task automatic test_random(int unsigned count);
    logic [AddrW-1:0] base;
    logic [AddrW-1:0] a;
    logic [AddrW-1:0] sz;
    rtlc_pkg::req_t r;
    int unsigned pick;
    base = user_lo;
    for (int i = 0; i < count; i++) begin
      if (i % 40 == 39) base = user_lo + AddrW'($urandom_range(0, 255) << 12);
      pick = $urandom_range(0, 99);
      a = base + AddrW'($urandom_range(0, 63) << 12) + AddrW'($urandom_range(0, 3) == 0 ?
          $urandom_range(0, 4095) : 0);
      sz = AddrW'($urandom_range(1, 8) << 12);
      r = make_req(rtlc_pkg::OpLookup, a, a + sz, sz, 4'($urandom()), 1'($urandom()));
      if (pick < 4) begin
        r = make_req(2'($urandom()), rand_addr(), rand_addr(), rand_addr(),
                     4'($urandom()), 1'($urandom()));
      end else if (pick < 6) begin
        r.operation = rtlc_pkg::OpClear;
      end else if (pick < 40) begin
        r.operation = rtlc_pkg::OpInsert;
        if ($urandom_range(0, 15) == 0) r.region_limit = a - AddrW'($urandom_range(0, 2));
      end else if (pick < 60) begin
        r.operation = rtlc_pkg::OpLookup;
      end else begin
        r.operation = rtlc_pkg::OpCheck;
        r.length = ($urandom_range(0, 15) == 0) ? '0 : AddrW'($urandom_range(1, 5 << 12));
      end
      send_item(r);
    end
  endtask

  initial begin
    rst_n = 1'b0;
    start = 1'b0;
    req = '0;
    cfg_valid = 1'b0;
    cfg_index = rtlc_pkg::CfgUserStart;
    cfg_data = '0;
    n_mismatch = 0;
    n_items = 0;
    n_rsp = 0;
    n_hits = 0;
    n_ok_checks = 0;
    n_cycles = 0;
    tbl_count = 0;
    last_idx = 0;
    last_valid = 1'b0;
    user_lo = 39'h200000;
    user_hi = 39'h80000000;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed();
    test_random(250);
    write_bound(rtlc_pkg::CfgUserStart, '0);
    write_bound(rtlc_pkg::CfgUserTop, '1);
    test_directed();
    test_random(250);
    write_bound(rtlc_pkg::CfgUserStart, '1);
    write_bound(rtlc_pkg::CfgUserTop, '0);
    test_random(60);
    write_bound(rtlc_pkg::CfgUserStart, 39'h7f_0000_0000);
    write_bound(rtlc_pkg::CfgUserTop, 39'h7f_4000_0000);
    test_random(200);

    drain_results();
    repeat (100) @(posedge clk);
    $display("Sent %0d items, checked %0d results: %0d lookup hits, %0d permitted ranges.",
             n_items, n_rsp, n_hits, n_ok_checks);
    $display("Covered all insert statuses, stack guard, clear and four bound settings.");
    if (n_mismatch == 0 && pending_rsp.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("%0d mismatches", n_mismatch);
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
